// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sssp_pkg.sv -----
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared codes and constants of the shortest path block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sssp_pkg;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EDGE_FULL = 2'd1,
        ST_HEAP_OVF  = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;

endpackage

// ----- rtl/core/single_source_shortest_path_top.sv -----
// ----------------------------------------------------------------------------
// single_source_shortest_path_top
// Graph loader and Dijkstra query engine over adjacency and heap memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction:
//   add edge, query, or clear. Output channel (out_valid/out_ready) carries
//   one result transaction per query and per add that finds the edge store
//   full. Adds and clears that succeed give no result.
//   Add edge: list head read, then edge and head write.
//   Clear: a pass writing every list head empty.
//   Query: a pass setting all distances to infinity, then per heap pop a
//   read of root and last entry, a sift-down by levels and a check that
//   the pair is current, then per edge a read of the edge and of its
//   neighbour's distance, plus a sift-up for a push; every step is one
//   access of a RAM with registered read data. After reset the same list
//   head clearing pass runs; in_ready stays low meanwhile.
//   A result sits in the output register until taken; the next command is
//   accepted while it waits, and a further result waits for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module single_source_shortest_path_top
    import sssp_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_EDGES  = 4096,
    parameter int HEAP_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [9:0]  edge_from,
    input  logic [9:0]  edge_to,
    input  logic [15:0] edge_weight,
    input  logic [9:0]  source_node,
    input  logic [9:0]  target_node,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] shortest_distance,
    output logic        reachable,
    output logic [1:0]  status
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int HW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HCW = $clog2(HEAP_DEPTH + 1);
    localparam int LHW = 1 + EW;
    localparam int ESW = NW + 16 + 1 + EW;
    localparam int HSW = NW + 32;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ADD, S_QINIT, S_QSRC, S_POP0, S_POP1, S_POP2,
        S_SD0, S_SD1, S_SD2, S_CHK, S_CHK1, S_LH, S_E0, S_E1, S_E2,
        S_SU0, S_SU1, S_FIN, S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [ECW-1:0]    ec_reg, ec_next;
    logic [HCW-1:0]    hc_reg, hc_next;
    logic [HW-1:0]     i_reg, i_next;
    logic [NW-1:0]     x_node_reg, x_node_next;
    logic [31:0]       x_dist_reg, x_dist_next;
    logic [NW-1:0]     cur_node_reg, cur_node_next;
    logic [31:0]       cur_dist_reg, cur_dist_next;
    logic [HSW-1:0]    lval_reg, lval_next;
    logic              lk_valid_reg, lk_valid_next;
    logic [EW-1:0]     lk_idx_reg, lk_idx_next;
    logic [NW-1:0]     eto_reg, eto_next;
    logic [31:0]       nd_reg, nd_next;
    logic [NW-1:0]     from_reg, from_next;
    logic [NW-1:0]     to_reg, to_next;
    logic [15:0]       w_reg, w_next;
    logic [NW-1:0]     src_reg, src_next;
    logic              src_ok_reg, src_ok_next;
    logic [NW-1:0]     tgt_reg, tgt_next;
    logic              tgt_ok_reg, tgt_ok_next;
    logic [31:0]       res_reg, res_next;
    status_t           rst_reg, rst_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_dist_reg, out_dist_next;
    logic              out_reach_reg, out_reach_next;
    logic [1:0]        out_stat_reg, out_stat_next;

    // memory ports
    logic              lh_we;
    logic [NW-1:0]     lh_waddr, lh_raddr;
    logic [LHW-1:0]    lh_wdata, lh_rdata;
    logic              es_we;
    logic [EW-1:0]     es_waddr, es_raddr;
    logic [ESW-1:0]    es_wdata, es_rdata;
    logic              nd_we;
    logic [NW-1:0]     nd_waddr, nd_raddr;
    logic [31:0]       nd_wdata, nd_rdata;
    logic              hp_we;
    logic [HW-1:0]     hp_waddr, hp_raddr;
    logic [HSW-1:0]    hp_wdata, hp_rdata;

    logic [HW+1:0]     l_idx, r_idx;
    logic [HW+1:0]     hc_ext;
    logic [32:0]       sum;
    logic [HSW-1:0]    cand;
    logic [HW-1:0]     cand_idx;
    logic [HW-1:0]     p_idx;

    sssp_ram #(.DEPTH(MAX_NODES), .WIDTH(LHW)) u_list_head (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata)
    );

    sssp_ram #(.DEPTH(MAX_EDGES), .WIDTH(ESW)) u_edge_store (
        .clk(clk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
        .raddr(es_raddr), .rdata(es_rdata)
    );

    sssp_ram #(.DEPTH(MAX_NODES), .WIDTH(32)) u_node_dist (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );

    sssp_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(HSW)) u_heap (
        .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata)
    );

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign shortest_distance = out_dist_reg;
    assign reachable         = out_reach_reg;
    assign status            = out_stat_reg;

    assign l_idx  = {1'b0, i_reg, 1'b1};
    assign r_idx  = l_idx + 1'b1;
    assign hc_ext = (HW + 2)'(hc_reg);
    assign p_idx  = HW'((i_reg - 1'b1) >> 1);
    assign sum    = {1'b0, cur_dist_reg} + {17'b0, es_rdata[EW+16:EW+1]};

    // smaller child; left wins a tie
    always_comb
    begin
        if (state_reg == S_SD2 && hp_rdata[31:0] < lval_reg[31:0])
        begin
            cand     = hp_rdata;
            cand_idx = r_idx[HW-1:0];
        end
        else if (state_reg == S_SD2)
        begin
            cand     = lval_reg;
            cand_idx = l_idx[HW-1:0];
        end
        else
        begin
            cand     = hp_rdata;
            cand_idx = l_idx[HW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ec_next        = ec_reg;
        hc_next        = hc_reg;
        i_next         = i_reg;
        x_node_next    = x_node_reg;
        x_dist_next    = x_dist_reg;
        cur_node_next  = cur_node_reg;
        cur_dist_next  = cur_dist_reg;
        lval_next      = lval_reg;
        lk_valid_next  = lk_valid_reg;
        lk_idx_next    = lk_idx_reg;
        eto_next       = eto_reg;
        nd_next        = nd_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        w_next         = w_reg;
        src_next       = src_reg;
        src_ok_next    = src_ok_reg;
        tgt_next       = tgt_reg;
        tgt_ok_next    = tgt_ok_reg;
        res_next       = res_reg;
        rst_next       = rst_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_reach_next = out_reach_reg;
        out_stat_next  = out_stat_reg;

        lh_we = 1'b0; lh_waddr = cnt_reg; lh_wdata = '0; lh_raddr = from_reg;
        es_we = 1'b0; es_waddr = EW'(ec_reg); es_wdata = '0; es_raddr = lk_idx_reg;
        nd_we = 1'b0; nd_waddr = cnt_reg; nd_wdata = DIST_INF; nd_raddr = cur_node_reg;
        hp_we = 1'b0; hp_waddr = i_reg; hp_wdata = {x_node_reg, x_dist_reg};
        hp_raddr = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                lh_we   = 1'b1;
                ec_next = '0;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == 32'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                from_next   = NW'(edge_from);
                to_next     = NW'(edge_to);
                w_next      = edge_weight;
                src_next    = NW'(source_node);
                src_ok_next = 32'(source_node) < 32'(MAX_NODES);
                tgt_next    = NW'(target_node);
                tgt_ok_next = 32'(target_node) < 32'(MAX_NODES);
                lh_raddr    = NW'(edge_from);
                cnt_next    = '0;
                if (in_valid)
                begin
                    case (action_t'(action))
                        ACT_ADD:
                        begin
                            if (32'(edge_from) < 32'(MAX_NODES) &&
                                32'(edge_to) < 32'(MAX_NODES))
                            begin
                                if (32'(ec_reg) >= 32'(MAX_EDGES))
                                begin
                                    res_next   = DIST_INF;
                                    rst_next   = ST_EDGE_FULL;
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    state_next = S_ADD;
                                end
                            end
                        end
                        ACT_QUERY: state_next = S_QINIT;
                        ACT_CLEAR: state_next = S_CLR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                es_we      = 1'b1;
                es_wdata   = {to_reg, w_reg, lh_rdata};
                lh_we      = 1'b1;
                lh_waddr   = from_reg;
                lh_wdata   = {1'b1, EW'(ec_reg)};
                ec_next    = ec_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_QINIT:
            begin
                nd_we    = 1'b1;
                hc_next  = '0;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == 32'(MAX_NODES - 1))
                begin
                    state_next = S_QSRC;
                end
            end
            S_QSRC:
            begin
                if (src_ok_reg)
                begin
                    nd_we       = 1'b1;
                    nd_waddr    = src_reg;
                    nd_wdata    = '0;
                    hp_we       = 1'b1;
                    hp_waddr    = '0;
                    hp_wdata    = {src_reg, 32'd0};
                    hc_next     = HCW'(1);
                end
                state_next = S_POP0;
            end
            S_POP0:
            begin
                if (hc_reg == '0)
                begin
                    nd_raddr = tgt_reg;
                    if (tgt_ok_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        res_next   = DIST_INF;
                        rst_next   = ST_OK;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    hp_raddr   = '0;
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                cur_node_next = hp_rdata[HSW-1:32];
                cur_dist_next = hp_rdata[31:0];
                hp_raddr      = HW'(hc_reg - 1'b1);
                state_next    = S_POP2;
            end
            S_POP2:
            begin
                x_node_next = hp_rdata[HSW-1:32];
                x_dist_next = hp_rdata[31:0];
                hc_next     = hc_reg - 1'b1;
                i_next      = '0;
                state_next  = S_SD0;
            end
            S_SD0:
            begin
                // the sifted entry is held in x; its slot is written at the end
                if (l_idx >= hc_ext)
                begin
                    hp_we      = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    hp_raddr   = l_idx[HW-1:0];
                    state_next = S_SD1;
                end
            end
            S_SD1, S_SD2:
            begin
                lval_next = hp_rdata;
                if (state_reg == S_SD1 && r_idx < hc_ext)
                begin
                    hp_raddr   = r_idx[HW-1:0];
                    state_next = S_SD2;
                end
                else if (cand[31:0] < x_dist_reg)
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = cand;
                    i_next     = cand_idx;
                    state_next = S_SD0;
                end
                else
                begin
                    hp_we      = 1'b1;
                    state_next = S_CHK;
                end
                if (state_reg == S_SD2)
                begin
                    lval_next = lval_reg;
                end
            end
            S_CHK:
            begin
                nd_raddr   = cur_node_reg;
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                lh_raddr = cur_node_reg;
                if (nd_rdata != cur_dist_reg)
                begin
                    state_next = S_POP0;
                end
                else
                begin
                    state_next = S_LH;
                end
            end
            S_LH:
            begin
                lk_valid_next = lh_rdata[EW];
                lk_idx_next   = lh_rdata[EW-1:0];
                state_next    = S_E0;
            end
            S_E0:
            begin
                es_raddr = lk_idx_reg;
                if (lk_valid_reg && ECW'(lk_idx_reg) < ec_reg)
                begin
                    state_next = S_E1;
                end
                else
                begin
                    state_next = S_POP0;
                end
            end
            S_E1:
            begin
                eto_next      = es_rdata[ESW-1 -: NW];
                nd_next       = sum[32] ? DIST_INF : sum[31:0];
                lk_valid_next = es_rdata[EW];
                lk_idx_next   = es_rdata[EW-1:0];
                nd_raddr      = es_rdata[ESW-1 -: NW];
                state_next    = S_E2;
            end
            S_E2:
            begin
                if (nd_reg < nd_rdata)
                begin
                    nd_we    = 1'b1;
                    nd_waddr = eto_reg;
                    nd_wdata = nd_reg;
                    if (32'(hc_reg) >= 32'(HEAP_DEPTH))
                    begin
                        hc_next    = '0;
                        res_next   = DIST_INF;
                        rst_next   = ST_HEAP_OVF;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        x_node_next = eto_reg;
                        x_dist_next = nd_reg;
                        i_next      = HW'(hc_reg);
                        hc_next     = hc_reg + 1'b1;
                        state_next  = S_SU0;
                    end
                end
                else
                begin
                    state_next = S_E0;
                end
            end
            S_SU0:
            begin
                hp_raddr = p_idx;
                if (i_reg == '0)
                begin
                    hp_we      = 1'b1;
                    state_next = S_E0;
                end
                else
                begin
                    state_next = S_SU1;
                end
            end
            S_SU1:
            begin
                hp_we = 1'b1;
                if (hp_rdata[31:0] > x_dist_reg)
                begin
                    hp_wdata   = hp_rdata;
                    i_next     = p_idx;
                    state_next = S_SU0;
                end
                else
                begin
                    state_next = S_E0;
                end
            end
            S_FIN:
            begin
                res_next   = nd_rdata;
                rst_next   = ST_OK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = res_reg;
                    out_reach_next = (res_reg != DIST_INF) && (rst_reg == ST_OK);
                    out_stat_next  = rst_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            ec_reg        <= '0;
            hc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ec_reg        <= ec_next;
            hc_reg        <= hc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        x_node_reg    <= x_node_next;
        x_dist_reg    <= x_dist_next;
        cur_node_reg  <= cur_node_next;
        cur_dist_reg  <= cur_dist_next;
        lval_reg      <= lval_next;
        lk_valid_reg  <= lk_valid_next;
        lk_idx_reg    <= lk_idx_next;
        eto_reg       <= eto_next;
        nd_reg        <= nd_next;
        from_reg      <= from_next;
        to_reg        <= to_next;
        w_reg         <= w_next;
        src_reg       <= src_next;
        src_ok_reg    <= src_ok_next;
        tgt_reg       <= tgt_next;
        tgt_ok_reg    <= tgt_ok_next;
        res_reg       <= res_next;
        rst_reg       <= rst_next;
        out_dist_reg  <= out_dist_next;
        out_reach_reg <= out_reach_next;
        out_stat_reg  <= out_stat_next;
    end

    `ASSERT_ALWAYS(a_heap_bound, 32'(hc_reg) <= 32'(HEAP_DEPTH), "heap count past depth")
    `ASSERT_ALWAYS(a_edge_bound, 32'(ec_reg) <= 32'(MAX_EDGES), "edge count past store size")
    `ASSERT_IMPLIES(a_reach_ok, out_valid_reg && out_reach_reg,
        out_dist_reg != DIST_INF && out_stat_reg == ST_OK, "reachable with bad distance")
    `ASSERT_IMPLIES(a_err_unreach, out_valid_reg && out_stat_reg != ST_OK,
        !out_reach_reg && out_dist_reg == DIST_INF, "error result marked reachable")

endmodule

// ----- rtl/core/sssp_ram.sv -----
// ----------------------------------------------------------------------------
// sssp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sssp_ram
    import sssp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
